@@ hw/rtl/scbs_pkg.sv @@
// shared constants, types, microcode table and condition decode of the sorted code table
`default_nettype none
package scbs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W      = 32;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;
  localparam int INDEX_W     = 8;
  localparam int ENTRIES_W   = 9;

  // actions
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABOVE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  // microprogram addresses
  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t S_L0     = 5'd0;
  localparam pc_t S_L1     = 5'd1;
  localparam pc_t S_L2     = 5'd2;
  localparam pc_t S_L3     = 5'd3;
  localparam pc_t S_L4     = 5'd4;
  localparam pc_t S_L5     = 5'd5;
  localparam pc_t S_I0     = 5'd6;
  localparam pc_t S_I1     = 5'd7;
  localparam pc_t S_IW     = 5'd8;
  localparam pc_t S_FOK    = 5'd9;
  localparam pc_t S_FZERO  = 5'd10;
  localparam pc_t S_FNF    = 5'd11;
  localparam pc_t S_FBELOW = 5'd12;
  localparam pc_t S_FABOVE = 5'd13;
  localparam pc_t S_FFULL  = 5'd14;
  localparam pc_t S_FCLR   = 5'd15;
  localparam pc_t S_FNOP   = 5'd16;

  // branch conditions
  typedef logic [3:0] cond_t;
  localparam cond_t C_NEVER   = 4'd0;
  localparam cond_t C_KEYZ    = 4'd1;
  localparam cond_t C_EMPTY   = 4'd2;
  localparam cond_t C_FULL    = 4'd3;
  localparam cond_t C_EQ      = 4'd4;
  localparam cond_t C_GT      = 4'd5;
  localparam cond_t C_LT      = 4'd6;
  localparam cond_t C_LOOPEND = 4'd7;
  localparam cond_t C_NOSHIFT = 4'd8;

  // read address select
  typedef logic [2:0] rsel_t;
  localparam rsel_t RA_NONE   = 3'd0;
  localparam rsel_t RA_ZERO   = 3'd1;
  localparam rsel_t RA_HI     = 3'd2;
  localparam rsel_t RA_CNTM1  = 3'd3;
  localparam rsel_t RA_MID    = 3'd4;
  localparam rsel_t RA_NARROW = 3'd5;
  localparam rsel_t RA_PM2    = 3'd6;

  // write select
  typedef logic [1:0] wsel_t;
  localparam wsel_t WR_NONE = 2'd0;
  localparam wsel_t WR_Q    = 2'd1;
  localparam wsel_t WR_KEY  = 2'd2;

  // register operations
  typedef logic [1:0] op_t;
  localparam op_t LO_HOLD   = 2'd0;
  localparam op_t LO_ZERO   = 2'd1;
  localparam op_t LO_NARROW = 2'd2;
  localparam op_t HI_HOLD   = 2'd0;
  localparam op_t HI_CNTM1  = 2'd1;
  localparam op_t HI_NARROW = 2'd2;
  localparam op_t P_HOLD    = 2'd0;
  localparam op_t P_CNT     = 2'd1;
  localparam op_t P_DEC     = 2'd2;
  localparam op_t CNT_HOLD  = 2'd0;
  localparam op_t CNT_CLR   = 2'd1;
  localparam op_t CNT_INC   = 2'd2;

  // index source of the result
  typedef logic [1:0] isel_t;
  localparam isel_t IX_ZERO  = 2'd0;
  localparam isel_t IX_PADDR = 2'd1;
  localparam isel_t IX_P     = 2'd2;

  // one control word
  typedef struct packed {
    cond_t                 ca;
    pc_t                   ja;
    cond_t                 cb;
    pc_t                   jb;
    pc_t                   jn;
    rsel_t                 ra;
    wsel_t                 wr;
    op_t                   lo_op;
    op_t                   hi_op;
    logic                  mid_ld;
    op_t                   p_op;
    op_t                   cnt_op;
    logic                  fin;
    logic [STATUS_W-1:0]   status;
    isel_t                 isel;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic   go;
    logic   fin;
    uword_t w;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic keyz;
    logic empty;
    logic full;
    logic eq;
    logic gt;
    logic lt;
    logic loopend;
    logic noshift;
  } flags_t;

  // finishing word with a given status and index source
  function automatic uword_t fin_word(logic [STATUS_W-1:0] st, isel_t ix);
    uword_t w;
    w        = '0;
    w.fin    = 1'b1;
    w.status = st;
    w.isel   = ix;
    return w;
  endfunction

  // microprogram rom
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    w = '0;
    unique case (pc)
      // lookup: reject zero and empty table, probe first entry
      S_L0: begin
        w.ca = C_KEYZ;  w.ja = S_FZERO;
        w.cb = C_EMPTY; w.jb = S_FNF;
        w.jn = S_L1;
        w.ra = RA_ZERO; w.lo_op = LO_ZERO; w.hi_op = HI_CNTM1;
      end
      // first entry check, probe last entry
      S_L1: begin
        w.ca = C_EQ; w.ja = S_FOK;
        w.cb = C_GT; w.jb = S_FBELOW;
        w.jn = S_L2;
        w.ra = RA_HI;
      end
      // last entry check
      S_L2: begin
        w.ca = C_EQ; w.ja = S_FOK;
        w.cb = C_LT; w.jb = S_FABOVE;
        w.jn = S_L3;
      end
      // loop test, probe midpoint
      S_L3: begin
        w.ca = C_LOOPEND; w.ja = S_FNF;
        w.jn = S_L4;
        w.ra = RA_MID; w.mid_ld = 1'b1;
      end
      // midpoint check, narrow and probe the neighbor
      S_L4: begin
        w.ca = C_EQ; w.ja = S_FOK;
        w.jn = S_L5;
        w.ra = RA_NARROW; w.lo_op = LO_NARROW; w.hi_op = HI_NARROW;
      end
      // neighbor check
      S_L5: begin
        w.ca = C_EQ; w.ja = S_FOK;
        w.jn = S_L3;
      end
      // insert: reject zero and full table, read last entry
      S_I0: begin
        w.ca = C_KEYZ; w.ja = S_FZERO;
        w.cb = C_FULL; w.jb = S_FFULL;
        w.jn = S_I1;
        w.ra = RA_CNTM1; w.p_op = P_CNT;
      end
      // shift larger entries up one place
      S_I1: begin
        w.ca = C_NOSHIFT; w.ja = S_IW;
        w.jn = S_I1;
        w.wr = WR_Q; w.p_op = P_DEC; w.ra = RA_PM2;
      end
      // place the new code
      S_IW: begin
        w        = fin_word(ST_OK, IX_P);
        w.wr     = WR_KEY;
        w.cnt_op = CNT_INC;
      end
      S_FOK:    w = fin_word(ST_OK, IX_PADDR);
      S_FZERO:  w = fin_word(ST_ZERO, IX_ZERO);
      S_FNF:    w = fin_word(ST_NOT_FOUND, IX_ZERO);
      S_FBELOW: w = fin_word(ST_BELOW, IX_ZERO);
      S_FABOVE: w = fin_word(ST_ABOVE, IX_ZERO);
      S_FFULL:  w = fin_word(ST_FULL, IX_ZERO);
      S_FCLR: begin
        w        = fin_word(ST_OK, IX_ZERO);
        w.cnt_op = CNT_CLR;
      end
      default:  w = fin_word(ST_OK, IX_ZERO);
    endcase
    return w;
  endfunction

  // first step of each action
  function automatic pc_t entry_pc(logic [ACTION_W-1:0] act);
    pc_t pc;
    unique case (act)
      ACT_CLEAR:  pc = S_FCLR;
      ACT_INSERT: pc = S_I0;
      ACT_LOOKUP: pc = S_L0;
      default:    pc = S_FNOP;
    endcase
    return pc;
  endfunction

  // branch condition decode
  function automatic logic cond_true(cond_t c, flags_t f);
    logic r;
    unique case (c)
      C_KEYZ:    r = f.keyz;
      C_EMPTY:   r = f.empty;
      C_FULL:    r = f.full;
      C_EQ:      r = f.eq;
      C_GT:      r = f.gt;
      C_LT:      r = f.lt;
      C_LOOPEND: r = f.loopend;
      C_NOSHIFT: r = f.noshift;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/scbs_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module scbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/scbs_seq.sv @@
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none
module scbs_seq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [scbs_pkg::ACTION_W-1:0]    action,
  input  wire scbs_pkg::flags_t                 flags,
  output logic                                  busy,
  output scbs_pkg::ctrl_t                       ctrl
);

  logic            run_r, run_nxt;
  scbs_pkg::pc_t   pc_r, pc_nxt;
  scbs_pkg::uword_t w;
  logic            fa, fb;

  // current control word and branch outcome
  always_comb begin
    w  = scbs_pkg::ucode(pc_r);
    fa = scbs_pkg::cond_true(w.ca, flags);
    fb = scbs_pkg::cond_true(w.cb, flags);
    ctrl.w   = w;
    ctrl.go  = run_r && !fa && !fb;
    ctrl.fin = run_r && w.fin;
  end

  // next step
  always_comb begin
    pc_nxt  = pc_r;
    run_nxt = run_r;
    if (!run_r) begin
      if (start) begin
        run_nxt = 1'b1;
        pc_nxt  = scbs_pkg::entry_pc(action);
      end
    end else if (w.fin) begin
      run_nxt = 1'b0;
    end else if (fa) begin
      pc_nxt = w.ja;
    end else if (fb) begin
      pc_nxt = w.jb;
    end else begin
      pc_nxt = w.jn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pc_r  <= scbs_pkg::S_FNOP;
    end else begin
      run_r <= run_nxt;
      pc_r  <= pc_nxt;
    end
  end

  assign busy = run_r;

endmodule
`default_nettype wire

@@ hw/rtl/sorted_code_table_binary_search.sv @@
// top level: sorted code table datapath with microcoded insert and binary search
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  input    | in_action, in_code                      | start high, busy low
//  result   | out_status, out_index, out_entries      | out_strobe, one cycle
//
// an item runs one microprogram; the result strobe follows the finishing step.
// clear and unused actions finish in their entry step; zero code, empty table
// and full table rejections branch from the first step to a finishing step.
// lookup: first and last entry checks, then rounds of midpoint and neighbor probes;
// every step is bound by the single read port of the code ram.
// insert: a check step, a shift step for each entry moved up, then the new code.
// synchronous reset empties the table at once; no clearing pass. busy is high
// while a program runs; the receiver cannot stall, results are never held.
`default_nettype none
module sorted_code_table_binary_search (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [scbs_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [scbs_pkg::CODE_W-1:0]      in_code,
  output logic                                  out_strobe,
  output logic      [scbs_pkg::STATUS_W-1:0]    out_status,
  output logic      [scbs_pkg::INDEX_W-1:0]     out_index,
  output logic      [scbs_pkg::ENTRIES_W-1:0]   out_entries
);

  localparam int AW = scbs_pkg::ADDR_W;
  localparam int CW = scbs_pkg::CNT_W;

  scbs_pkg::ctrl_t  ctrl;
  scbs_pkg::flags_t flags;

  logic [scbs_pkg::CODE_W-1:0] key_r;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [AW-1:0]               lo_r, lo_nxt;
  logic [AW-1:0]               hi_r, hi_nxt;
  logic [AW-1:0]               mid_r, mid_nxt;
  logic [AW-1:0]               p_r, p_nxt;
  logic [AW-1:0]               paddr_r, paddr_nxt;
  logic [AW:0]                 mid_sum;
  logic [AW-1:0]               mid_c;
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [scbs_pkg::CODE_W-1:0] ram_wdata, q;
  logic                        strobe_r;
  logic [scbs_pkg::STATUS_W-1:0]  status_r;
  logic [scbs_pkg::INDEX_W-1:0]   index_r, index_nxt;
  logic [scbs_pkg::ENTRIES_W-1:0] entries_r;
  logic                        accept;

  assign accept = start && !busy;

  scbs_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .flags  (flags),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  scbs_ram #(
    .WIDTH (scbs_pkg::CODE_W),
    .DEPTH (scbs_pkg::TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (q)
  );

  // compare flags for the sequencer
  always_comb begin
    flags.keyz    = (key_r == '0);
    flags.empty   = (cnt_r == '0);
    flags.full    = (cnt_r == CW'(scbs_pkg::TABLE_DEPTH));
    flags.eq      = (q == key_r);
    flags.gt      = (q > key_r);
    flags.lt      = (q < key_r);
    flags.loopend = ({1'b0, hi_r} <= ({1'b0, lo_r} + (AW+1)'(1)));
    flags.noshift = (p_r == '0) || !(q > key_r);
  end

  // midpoint
  always_comb begin
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
    mid_c   = AW'(mid_sum >> 1);
  end

  // read address and ram write
  always_comb begin
    unique case (ctrl.w.ra)
      scbs_pkg::RA_ZERO:   ram_raddr = '0;
      scbs_pkg::RA_HI:     ram_raddr = hi_r;
      scbs_pkg::RA_CNTM1:  ram_raddr = AW'(cnt_r - CW'(1));
      scbs_pkg::RA_MID:    ram_raddr = mid_c;
      scbs_pkg::RA_NARROW: ram_raddr = flags.gt ? (mid_r - AW'(1)) : (mid_r + AW'(1));
      scbs_pkg::RA_PM2:    ram_raddr = p_r - AW'(2);
      default:             ram_raddr = paddr_r;
    endcase
    ram_re    = ctrl.go && (ctrl.w.ra != scbs_pkg::RA_NONE);
    paddr_nxt = ram_re ? ram_raddr : paddr_r;
    ram_we    = ctrl.go && (ctrl.w.wr != scbs_pkg::WR_NONE);
    ram_wdata = (ctrl.w.wr == scbs_pkg::WR_KEY) ? key_r : q;
  end

  // search bounds, insert position and count
  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    mid_nxt = mid_r;
    p_nxt   = p_r;
    cnt_nxt = cnt_r;
    if (ctrl.go) begin
      unique case (ctrl.w.lo_op)
        scbs_pkg::LO_ZERO:   lo_nxt = '0;
        scbs_pkg::LO_NARROW: lo_nxt = flags.gt ? lo_r : (mid_r + AW'(1));
        default:             lo_nxt = lo_r;
      endcase
      unique case (ctrl.w.hi_op)
        scbs_pkg::HI_CNTM1:  hi_nxt = AW'(cnt_r - CW'(1));
        scbs_pkg::HI_NARROW: hi_nxt = flags.gt ? (mid_r - AW'(1)) : hi_r;
        default:             hi_nxt = hi_r;
      endcase
      if (ctrl.w.mid_ld) begin
        mid_nxt = mid_c;
      end
      unique case (ctrl.w.p_op)
        scbs_pkg::P_CNT: p_nxt = AW'(cnt_r);
        scbs_pkg::P_DEC: p_nxt = p_r - AW'(1);
        default:         p_nxt = p_r;
      endcase
      unique case (ctrl.w.cnt_op)
        scbs_pkg::CNT_CLR: cnt_nxt = '0;
        scbs_pkg::CNT_INC: cnt_nxt = cnt_r + CW'(1);
        default:           cnt_nxt = cnt_r;
      endcase
    end
  end

  // result index
  always_comb begin
    unique case (ctrl.w.isel)
      scbs_pkg::IX_PADDR: index_nxt = scbs_pkg::INDEX_W'(paddr_r);
      scbs_pkg::IX_P:     index_nxt = scbs_pkg::INDEX_W'(p_r);
      default:            index_nxt = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      strobe_r <= ctrl.fin;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_code;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    p_r     <= p_nxt;
    paddr_r <= paddr_nxt;
    if (ctrl.fin) begin
      status_r  <= ctrl.w.status;
      index_r   <= index_nxt;
      entries_r <= scbs_pkg::ENTRIES_W'(cnt_nxt);
    end
  end

  assign out_strobe  = strobe_r;
  assign out_status  = status_r;
  assign out_index   = index_r;
  assign out_entries = entries_r;

  // the result beat comes after the program has ended
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$past(busy, 1) || $past(ctrl.fin, 1))
    else $error("result beat without a finishing step");

  // the count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(scbs_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // an accepted item starts a program
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not start");

  // a full report only comes with a full table
  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == scbs_pkg::ST_FULL)) |->
      (out_entries == scbs_pkg::ENTRIES_W'(scbs_pkg::TABLE_DEPTH)))
    else $error("table full reported on a table with room");

endmodule
`default_nettype wire

@@ sim/code_table_check_pkg.sv @@
// scoreboard class with the sorted code table predictor and the expected result store
package code_table_check_pkg;
  import scbs_pkg::*;

  // action value that the block ignores
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // one result beat
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [INDEX_W-1:0]   index;
    logic [ENTRIES_W-1:0] entries;
  } table_result_t;

  class code_table_scoreboard;
    logic [CODE_W-1:0] codes [TABLE_DEPTH];
    int                count;
    table_result_t     expected_results [$];
    int                errors;

    function new();
      count  = 0;
      errors = 0;
      foreach (codes[i]) codes[i] = '0;
    endfunction

    // sorted insert, new code goes after all equal codes
    function table_result_t insert_code(logic [CODE_W-1:0] key);
      table_result_t r;
      int p;
      r = '0;
      if (key == '0) begin
        r.status = ST_ZERO;
        return r;
      end
      if (count >= TABLE_DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      p = count;
      while (p > 0 && codes[p-1] > key) begin
        codes[p] = codes[p-1];
        p--;
      end
      codes[p] = key;
      count++;
      r.index = INDEX_W'(p);
      return r;
    endfunction

    // bound checks then binary search that also probes the neighbor of each midpoint
    function table_result_t search_code(logic [CODE_W-1:0] key);
      table_result_t r;
      int lo, hi, mid;
      r = '0;
      if (key == '0) begin
        r.status = ST_ZERO;
        return r;
      end
      if (count == 0) begin
        r.status = ST_NOT_FOUND;
        return r;
      end
      lo = 0;
      if (codes[lo] == key) return r;
      if (codes[lo] > key) begin
        r.status = ST_BELOW;
        return r;
      end
      hi = count - 1;
      if (codes[hi] == key) begin
        r.index = INDEX_W'(hi);
        return r;
      end
      if (codes[hi] < key) begin
        r.status = ST_ABOVE;
        return r;
      end
      while (hi > lo + 1) begin
        mid = (lo + hi) >> 1;
        if (codes[mid] == key) begin
          r.index = INDEX_W'(mid);
          return r;
        end
        if (codes[mid] > key) begin
          hi = mid - 1;
          if (codes[hi] == key) begin
            r.index = INDEX_W'(hi);
            return r;
          end
        end else begin
          lo = mid + 1;
          if (codes[lo] == key) begin
            r.index = INDEX_W'(lo);
            return r;
          end
        end
      end
      r.status = ST_NOT_FOUND;
      return r;
    endfunction

    // accepted input beat: update the table and queue what it must produce
    function void note_item(logic [ACTION_W-1:0] action, logic [CODE_W-1:0] key);
      table_result_t r;
      r = '0;
      case (action)
        ACT_CLEAR:  count = 0;
        ACT_INSERT: r = insert_code(key);
        ACT_LOOKUP: r = search_code(key);
        default:    r = '0;
      endcase
      r.entries = ENTRIES_W'(count);
      expected_results.push_back(r);
    endfunction

    // result beat against the oldest expectation
    function void check_result(logic [STATUS_W-1:0] status, logic [INDEX_W-1:0] index,
                               logic [ENTRIES_W-1:0] entries);
      table_result_t e;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d index %0d entries %0d",
               status, index, entries);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (index !== e.index) begin
        $error("index mismatch: expected %0d, got %0d", e.index, index);
        errors++;
      end
      if (entries !== e.entries) begin
        $error("entries mismatch: expected %0d, got %0d", e.entries, entries);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // a code currently held, for lookups and duplicates
    function logic [CODE_W-1:0] held_code();
      if (count == 0) return 32'd1;
      return codes[$urandom_range(count - 1)];
    endfunction
  endclass

endpackage

@@ sim/testbench.sv @@
// testbench of the sorted code table: directed, full-table and random phases
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scbs_pkg::*;
  import code_table_check_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ACTION_W-1:0]  in_action = '0;
  logic [CODE_W-1:0]    in_code = '0;
  logic                 out_strobe;
  logic [STATUS_W-1:0]  out_status;
  logic [INDEX_W-1:0]   out_index;
  logic [ENTRIES_W-1:0] out_entries;

  code_table_scoreboard sb = new();
  int size_goal = 8;

  sorted_code_table_binary_search u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_code     (in_code),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_index   (out_index),
    .out_entries (out_entries)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_result(out_status, out_index, out_entries);
  end

  // run limit
  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // optional idle gap, then hold one beat until the block takes it
  task automatic send_item(input logic [ACTION_W-1:0] action, input logic [CODE_W-1:0] code,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= action;
    in_code   <= code;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(action, code);
  endtask

  // hold off the sender until every expected result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic int idle_gap(int idle_pct);
    int g;
    g = 0;
    while (g < 40 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  // table size at which the random stream clears, mostly small
  function automatic int pick_size_goal();
    int s;
    s = $urandom_range(99);
    if (s < 70) return $urandom_range(1, 16);
    if (s < 93) return $urandom_range(17, 64);
    return $urandom_range(65, TABLE_DEPTH);
  endfunction

  function automatic logic [CODE_W-1:0] insert_pick();
    int s;
    s = $urandom_range(99);
    if (s < 4) return '0;
    if (s < 30) return $urandom;
    if (s < 55) return $urandom_range(1, 64);
    if (s < 70) return sb.held_code();
    if (s < 80) return 32'hFFFF_FFFF - $urandom_range(3);
    if (s < 90) return $urandom_range(1, 4);
    return sb.held_code() + 32'd1;
  endfunction

  function automatic logic [CODE_W-1:0] lookup_pick();
    int s;
    logic [CODE_W-1:0] c;
    s = $urandom_range(99);
    if (s < 4) return '0;
    if (s < 50) return sb.held_code();
    if (s < 65) begin
      c = $urandom_range(1) ? sb.held_code() + 32'd1 : sb.held_code() - 32'd1;
      return (c == '0) ? 32'd1 : c;
    end
    if (s < 75) return $urandom;
    if (s < 85) return $urandom_range(1, 64);
    if (s < 92) return 32'hFFFF_FFFF;
    return 32'd1;
  endfunction

  // edges of the code range, each action and the lookup outcomes
  task automatic run_directed();
    send_item(ACT_CLEAR, 32'h0, 0);
    send_item(ACT_LOOKUP, 32'h1234, 0);
    send_item(ACT_LOOKUP, 32'h0, 0);
    send_item(ACT_INSERT, 32'h0, 0);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 0);
    // single entry table
    send_item(ACT_INSERT, 32'd100, 0);
    send_item(ACT_LOOKUP, 32'd100, 0);
    send_item(ACT_LOOKUP, 32'd50, 0);
    send_item(ACT_LOOKUP, 32'd150, 0);
    // extremes, middle and a duplicate
    send_item(ACT_INSERT, 32'hFFFF_FFFF, 0);
    send_item(ACT_INSERT, 32'd1, 0);
    send_item(ACT_INSERT, 32'h8000_0000, 0);
    send_item(ACT_INSERT, 32'h8000_0000, 0);
    send_item(ACT_INSERT, 32'd200, 0);
    send_item(ACT_LOOKUP, 32'd1, 0);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 0);
    send_item(ACT_LOOKUP, 32'h8000_0000, 0);
    send_item(ACT_LOOKUP, 32'h8000_0001, 0);
    send_item(ACT_LOOKUP, 32'h7FFF_FFFF, 0);
    send_item(ACT_LOOKUP, 32'd200, 0);
    send_item(ACT_LOOKUP, 32'd150, 0);
    send_item(ACT_UNUSED, 32'h5A5A_A5A5, 0);
    send_item(ACT_CLEAR, 32'hDEAD_BEEF, 0);
    send_item(ACT_LOOKUP, 32'd1, 0);
  endtask

  // ascending fill up to the full table, then the full and zero rejections
  task automatic run_full_table();
    send_item(ACT_CLEAR, 32'h0, 0);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(ACT_INSERT, (i + 1) * 32'd16_000_000 + $urandom_range(15_999_999), 0);
    send_item(ACT_INSERT, $urandom | 32'd1, 0);
    send_item(ACT_INSERT, 32'h0, 0);
    send_item(ACT_LOOKUP, 32'd1, 0);
    send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < 24; i++) send_item(ACT_LOOKUP, lookup_pick(), idle_gap(27));
    send_item(ACT_CLEAR, 32'h0, 0);
  endtask

  // random stream of clear / insert / lookup episodes
  task automatic run_random(input int items, input int idle_pct);
    logic [ACTION_W-1:0] action;
    logic [CODE_W-1:0]   code;
    int                  r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (sb.count >= size_goal || r < 2) begin
        action    = ACT_CLEAR;
        code      = $urandom;
        size_goal = pick_size_goal();
      end else if (r < 5) begin
        action = ACT_UNUSED;
        code   = $urandom;
      end else if (r < 48) begin
        action = ACT_INSERT;
        code   = insert_pick();
      end else begin
        action = ACT_LOOKUP;
        code   = lookup_pick();
      end
      send_item(action, code, idle_gap(idle_pct));
      if ($urandom_range(99) == 0) drain_results();
    end
  endtask

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain_results();
    run_full_table();
    drain_results();
    run_random(100, 0);
    drain_results();
    run_random(100, 87);
    drain_results();
    run_random(100, 27);
    drain_results();
    run_random(100, 0);
    drain_results();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/scbs_pkg.sv
hw/rtl/scbs_ram.sv
hw/rtl/scbs_seq.sv
hw/rtl/sorted_code_table_binary_search.sv
sim/code_table_check_pkg.sv
sim/testbench.sv
